// File: design/assert_macros.svh
// assertion shorthands shared by the sharpen block
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sh3_pkg.sv
// sh3_pkg: shared types, register codes and defaults of the 3x3 sharpen block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sh3_pkg;

    // default sizes for the top level parameters
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // field widths
    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int BF_W       = 9;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_FACTOR = 2'd2;

    // register reset values
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;
    localparam int BLEND_FACTOR_RST = 128;

    // unity blend weight in Q1.8
    localparam int BLEND_ONE = 256;

    // kernel center weight
    localparam int CENTER_WEIGHT = 5;

    // opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pix_t;

    // one line-memory word: item one line back and item two lines back
    typedef struct packed {
        pix_t older;
        pix_t newer;
    } ring_t;

    // 3x3 cross window, neighbors outside the frame already zeroed
    typedef struct packed {
        pix_t ctr;
        pix_t up;
        pix_t dn;
        pix_t lf;
        pix_t rt;
    } win_t;

    // position flags of a result
    typedef struct packed {
        logic eol;
        logic eof;
    } pos_t;

    typedef struct packed {
        pix_t rgb;
        pos_t pos;
    } res_t;

endpackage

`default_nettype wire

// File: design/sh3_pix_if.sv
// sh3_pix_if: valid/ready channel carrying one input pixel item
// depends on sh3_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sh3_pix_if;
    import sh3_pkg::*;

    logic             valid;
    logic             ready;
    logic             opcode;
    logic [PIX_W-1:0] pixel_red;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_blue;

    modport source (output valid, opcode, pixel_red, pixel_green, pixel_blue,
                    input ready);
    modport sink (input valid, opcode, pixel_red, pixel_green, pixel_blue,
                  output ready);
endinterface

`default_nettype wire

// File: design/sh3_res_if.sv
// sh3_res_if: valid/ready channel carrying one sharpened result item
// depends on sh3_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sh3_res_if;
    import sh3_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             end_of_line;
    logic             end_of_frame;

    modport source (output valid, out_red, out_green, out_blue, end_of_line,
                    end_of_frame, input ready);
    modport sink (input valid, out_red, out_green, out_blue, end_of_line,
                  end_of_frame, output ready);
endinterface

`default_nettype wire

// File: design/sh3_window.sv
// sh3_window: frame position counters, two-line ring memory and 3x3 window registers
// depends on sh3_pkg, sh3_pix_if and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sh3_window #(
    parameter int MAX_WIDTH  = sh3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sh3_pkg::MAX_HEIGHT_DEF,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    sh3_pix_if.sink       pixels,
    input  logic          space,
    input  logic          restart,
    input  logic [WW-1:0] width,
    input  logic [HW-1:0] height,
    output logic          emit,
    output sh3_pkg::win_t win,
    output sh3_pkg::pos_t pos
);
    import sh3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    // input position (newest item) and output position (window center)
    logic [CW-1:0] ic_reg, ic_next;
    logic [RW-1:0] ir_reg, ir_next;
    logic [CW-1:0] oc_reg, oc_next;
    logic [RW-1:0] orow_reg, orow_next;

    // ring pointers
    logic [CW-1:0] wptr_reg, wptr_next;
    logic [CW-1:0] rptr;

    // line memory and its registered read
    ring_t line_mem [MAX_WIDTH];
    ring_t rd_reg;
    ring_t wd_reg;
    logic  byp_reg;
    ring_t ring_eff;
    ring_t wdata;

    // window registers
    pix_t dn_reg;
    pix_t m1_reg;
    pix_t m2_reg;
    pix_t up_reg;

    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;
    logic          at_start;
    logic          in_frame;
    logic          take;
    logic          last_col_in;
    pix_t          pix_in;

    assign w_last   = CW'(width - WW'(1));
    assign h_last   = RW'(height) - RW'(1);
    assign at_start = (ic_reg == '0) && (ir_reg == '0);
    assign in_frame = ir_reg < RW'(height);

    // a flush at frame start is dropped without a trace
    assign pixels.ready = space;
    assign take = pixels.valid && space && !((pixels.opcode == OP_FLUSH) && at_start);

    // flush items and pixels past the frame act as zero padding
    always_comb
    begin
        if ((pixels.opcode == OP_PIXEL) && in_frame)
        begin
            pix_in = '{red: pixels.pixel_red, green: pixels.pixel_green,
                       blue: pixels.pixel_blue};
        end
        else
        begin
            pix_in = '0;
        end
    end

    // a result is due once one line plus one item is buffered
    assign emit = take && ((ir_reg >= RW'(2)) || ((ir_reg == RW'(1)) && (ic_reg != '0)));

    assign pos.eol     = oc_reg == w_last;
    assign pos.eof     = pos.eol && (orow_reg == h_last);
    assign last_col_in = ic_reg == w_last;

    // position counters
    always_comb
    begin
        ic_next   = ic_reg;
        ir_next   = ir_reg;
        oc_next   = oc_reg;
        orow_next = orow_reg;
        priority if (restart || (emit && pos.eof))
        begin
            ic_next   = '0;
            ir_next   = '0;
            oc_next   = '0;
            orow_next = '0;
        end
        else if (take)
        begin
            if (last_col_in)
            begin
                ic_next = '0;
                ir_next = ir_reg + RW'(1);
            end
            else
            begin
                ic_next = ic_reg + CW'(1);
            end
            if (emit)
            begin
                if (pos.eol)
                begin
                    oc_next   = '0;
                    orow_next = orow_reg + RW'(1);
                end
                else
                begin
                    oc_next = oc_reg + CW'(1);
                end
            end
        end
    end

    // ring pointers run modulo the line width
    assign rptr = (wptr_reg == w_last) ? '0 : wptr_reg + CW'(1);

    always_comb
    begin
        wptr_next = wptr_reg;
        priority if (restart)
        begin
            wptr_next = '0;
        end
        else if (take)
        begin
            wptr_next = rptr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic_reg   <= '0;
            ir_reg   <= '0;
            oc_reg   <= '0;
            orow_reg <= '0;
            wptr_reg <= '0;
            byp_reg  <= 1'b0;
        end
        else
        begin
            ic_reg   <= ic_next;
            ir_reg   <= ir_next;
            oc_reg   <= oc_next;
            orow_reg <= orow_next;
            wptr_reg <= wptr_next;
            if (take)
            begin
                byp_reg <= rptr == wptr_reg;
            end
        end
    end

    // one-item lines read the word written by the previous transfer
    assign ring_eff = byp_reg ? wd_reg : rd_reg;
    assign wdata    = '{older: ring_eff.newer, newer: pix_in};

    // line memory: one write and one registered read per transfer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            line_mem[wptr_reg] <= wdata;
            rd_reg             <= line_mem[rptr];
            wd_reg             <= wdata;
        end
    end

    // window shift
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dn_reg <= pix_in;
            m1_reg <= ring_eff.newer;
            m2_reg <= m1_reg;
            up_reg <= ring_eff.older;
        end
    end

    // zero padding at the frame border
    assign win.ctr = m1_reg;
    assign win.up  = (orow_reg != '0) ? up_reg : '0;
    assign win.dn  = (orow_reg != h_last) ? dn_reg : '0;
    assign win.lf  = (oc_reg != '0) ? m2_reg : '0;
    assign win.rt  = pos.eol ? '0 : ring_eff.newer;

    // checks
    `ASSERT_NEXT(a_eof_restarts, emit && pos.eof, (ic_reg == '0) && (ir_reg == '0) && (oc_reg == '0), "frame position not cleared after last result")
    `ASSERT_NOW(a_cols_in_line, 1'b1, (ic_reg <= w_last) && (oc_reg <= w_last) && (wptr_reg <= w_last), "column beyond line width")
    `ASSERT_NOW(a_out_behind_in, emit, (ir_reg > orow_reg), "result position not behind input position")

endmodule

`default_nettype wire

// File: design/sh3_kernel.sv
// sh3_kernel: cross-shaped sharpen sum, clamp and blend for three channels
// depends on sh3_pkg
`timescale 1ns / 1ps
`default_nettype none

module sh3_kernel (
    input  sh3_pkg::win_t                win,
    input  logic [sh3_pkg::BF_W-1:0]     factor,
    output sh3_pkg::pix_t                result
);
    import sh3_pkg::*;

    // sharpen then blend back onto the original value
    function automatic logic [PIX_W-1:0] blend_chan(
        input logic [PIX_W-1:0] c,
        input logic [PIX_W-1:0] u,
        input logic [PIX_W-1:0] d,
        input logic [PIX_W-1:0] l,
        input logic [PIX_W-1:0] r,
        input logic [BF_W-1:0]  f
    );
        logic        [11:0] c5;
        logic        [11:0] nsum;
        logic signed [11:0] s;
        logic [PIX_W-1:0]   sharp;
        logic [15:0]        fs;
        logic [16:0]        acc;
        logic [BF_W-1:0]    fi;
        logic [8:0]         v;
        c5   = 12'(c) * 12'(CENTER_WEIGHT);
        nsum = 12'(u) + 12'(d) + 12'(l) + 12'(r);
        s    = $signed(c5) - $signed(nsum);
        if (s < 0)
        begin
            sharp = '0;
        end
        else if (s > 12'sd255)
        begin
            sharp = '1;
        end
        else
        begin
            sharp = s[PIX_W-1:0];
        end
        fs  = 16'(f) * 16'(sharp);
        fi  = BF_W'(BLEND_ONE) - f;
        acc = 17'(fi) * 17'(c) + {1'b0, fs[15:8], 8'b0};
        v   = acc[16:8];
        blend_chan = (v > 9'd255) ? '1 : v[PIX_W-1:0];
    endfunction

    assign result.red   = blend_chan(win.ctr.red, win.up.red, win.dn.red,
                                     win.lf.red, win.rt.red, factor);
    assign result.green = blend_chan(win.ctr.green, win.up.green, win.dn.green,
                                     win.lf.green, win.rt.green, factor);
    assign result.blue  = blend_chan(win.ctr.blue, win.up.blue, win.dn.blue,
                                     win.lf.blue, win.rt.blue, factor);

endmodule

`default_nettype wire

// File: design/sh3_out_queue.sv
// sh3_out_queue: two-entry result register with skid slot toward the output channel
// depends on sh3_pkg, sh3_res_if and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sh3_out_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sh3_pkg::res_t din,
    output logic          space,
    sh3_res_if.source     results
);
    import sh3_pkg::*;

    localparam logic [1:0] CNT_FULL = 2'd2;

    logic [1:0] cnt_reg, cnt_next;
    res_t       slot0_reg, slot0_next;
    res_t       slot1_reg, slot1_next;
    logic       pop;

    assign space = cnt_reg != CNT_FULL;
    assign pop   = results.valid && results.ready;

    assign results.valid        = cnt_reg != 2'd0;
    assign results.out_red      = slot0_reg.rgb.red;
    assign results.out_green    = slot0_reg.rgb.green;
    assign results.out_blue     = slot0_reg.rgb.blue;
    assign results.end_of_line  = slot0_reg.pos.eol;
    assign results.end_of_frame = slot0_reg.pos.eof;

    // queue update, head always in slot 0
    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                begin
                    slot0_next = din;
                end
                else
                begin
                    slot1_next = din;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                cnt_next   = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (cnt_reg == CNT_FULL)
                begin
                    slot0_next = slot1_reg;
                    slot1_next = din;
                end
                else
                begin
                    slot0_next = din;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // checks
    `ASSERT_NOW(a_no_push_full, push, cnt_reg != CNT_FULL, "result pushed into a full queue")
    `ASSERT_NEXT(a_skid_moves_up, pop && !push && (cnt_reg == CNT_FULL), slot0_reg == $past(slot1_reg), "skid entry lost on transfer")

endmodule

`default_nettype wire

// File: design/sharpen_3x3_blend.sv
// sharpen_3x3_blend: top level, configuration registers and block wiring
// depends on sh3_pkg, sh3_pix_if, sh3_res_if, sh3_window, sh3_kernel, sh3_out_queue
//
//   channel   dir   handshake        payload
//   pixels    in    valid / ready    opcode, pixel_red, pixel_green, pixel_blue
//   results   out   valid / ready    out_red, out_green, out_blue, end_of_line,
//                                    end_of_frame
//   config    in    write_en         write_index, write_data
//
// one input transfer per cycle while the result queue has space; a result is registered into the
// result queue by the input transfer that completes its window, one line plus one item behind its own pixel
// the line memory gives one write and one registered read per transfer
// rst_n clears counters, pointers and the result queue; line memory is not cleared
// a two-entry result queue keeps input flowing while a result waits; pixels.ready
// drops only when both entries are held
`timescale 1ns / 1ps
`default_nettype none

module sharpen_3x3_blend #(
    parameter int MAX_WIDTH  = sh3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sh3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    sh3_pix_if.sink                          pixels,
    sh3_res_if.source                        results,
    input  logic                             write_en,
    input  logic [sh3_pkg::CFG_IDX_W-1:0]    write_index,
    input  logic [sh3_pkg::CFG_DATA_W-1:0]   write_data
);
    import sh3_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int W_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
    localparam int H_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

    logic [WW-1:0]   width_reg, width_next;
    logic [HW-1:0]   height_reg, height_next;
    logic [BF_W-1:0] factor_reg, factor_next;
    logic            restart;

    logic [FW_W-1:0] fw_raw;
    logic [FH_W-1:0] fh_raw;
    logic [BF_W-1:0] bf_raw;
    logic [31:0]     fw_sat;
    logic [31:0]     fh_sat;

    logic  emit;
    logic  space;
    win_t  win;
    pos_t  pos;
    pix_t  rgb;
    res_t  res;

    // configuration writes, saturated to the supported range
    assign fw_raw = write_data[FW_W-1:0];
    assign fh_raw = write_data[FH_W-1:0];
    assign bf_raw = write_data[BF_W-1:0];

    always_comb
    begin
        fw_sat = (fw_raw == '0) ? 32'd1 :
                 (32'(fw_raw) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(fw_raw);
        fh_sat = (fh_raw == '0) ? 32'd1 :
                 (32'(fh_raw) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(fh_raw);
        width_next  = width_reg;
        height_next = height_reg;
        factor_next = factor_reg;
        restart     = 1'b0;
        if (write_en)
        begin
            priority case (write_index)
                REG_FRAME_WIDTH:
                begin
                    width_next = WW'(fw_sat);
                    restart    = 1'b1;
                end
                REG_FRAME_HEIGHT:
                begin
                    height_next = HW'(fh_sat);
                    restart     = 1'b1;
                end
                REG_BLEND_FACTOR:
                begin
                    factor_next = (bf_raw > BF_W'(BLEND_ONE)) ? BF_W'(BLEND_ONE) : bf_raw;
                    restart     = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(W_RST);
            height_reg <= HW'(H_RST);
            factor_reg <= BF_W'(BLEND_FACTOR_RST);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            factor_reg <= factor_next;
        end
    end

    // window and line buffering
    sh3_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels),
        .space   (space),
        .restart (restart),
        .width   (width_reg),
        .height  (height_reg),
        .emit    (emit),
        .win     (win),
        .pos     (pos)
    );

    // sharpen and blend
    sh3_kernel u_kernel (
        .win    (win),
        .factor (factor_reg),
        .result (rgb)
    );

    assign res = '{rgb: rgb, pos: pos};

    // result register and skid slot
    sh3_out_queue u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (emit),
        .din     (res),
        .space   (space),
        .results (results)
    );

endmodule

`default_nettype wire
